// ----- design/tgc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touchpad gesture classifier package
// Shared event modes, trigger codes, register indexes and types.
// ----------------------------------------------------------------------------
package tgc_pkg;

    typedef enum logic [2:0] {
        MODE_SWIPE_BEGIN  = 3'd0,
        MODE_SWIPE_UPDATE = 3'd1,
        MODE_SWIPE_END    = 3'd2,
        MODE_PINCH_BEGIN  = 3'd3,
        MODE_PINCH_UPDATE = 3'd4,
        MODE_PINCH_END    = 3'd5,
        MODE_HOLD_BEGIN   = 3'd6,
        MODE_HOLD_END     = 3'd7
    } mode_t;

    typedef logic [2:0] trig_code_t;

    localparam trig_code_t TRIG_LEFT      = 3'd0;
    localparam trig_code_t TRIG_RIGHT     = 3'd1;
    localparam trig_code_t TRIG_UP        = 3'd2;
    localparam trig_code_t TRIG_DOWN      = 3'd3;
    localparam trig_code_t TRIG_PINCH_IN  = 3'd4;
    localparam trig_code_t TRIG_PINCH_OUT = 3'd5;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_TRIGGER_ENABLE   = 3'd0;
    localparam cfg_idx_t CFG_FORWARD_ENABLE   = 3'd1;
    localparam cfg_idx_t CFG_SWIPE_MIN_TRAVEL = 3'd2;
    localparam cfg_idx_t CFG_AXIS_RATIO       = 3'd3;
    localparam cfg_idx_t CFG_PINCH_IN_LIMIT   = 3'd4;
    localparam cfg_idx_t CFG_PINCH_OUT_LIMIT  = 3'd5;

    localparam logic [5:0]  SWIPE_TRIGGER_MASK = 6'b00_1111;
    localparam logic [5:0]  PINCH_TRIGGER_MASK = 6'b11_0000;
    localparam logic [15:0] SCALE_ONE          = 16'd256;

    typedef struct packed {
        logic       hit;
        trig_code_t code;
    } swipe_class_t;

endpackage

`default_nettype wire

// ----- design/tgc_swipe_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Swipe direction evaluator
// Takes the accumulated swipe travel and decides the swipe direction from
// the minimum travel and the axis dominance ratio.
// ----------------------------------------------------------------------------
module tgc_swipe_eval
    import tgc_pkg::*;
(
    input  wire logic signed [31:0] sum_x,
    input  wire logic signed [31:0] sum_y,
    input  wire logic        [15:0] min_travel,
    input  wire logic        [7:0]  axis_ratio,
    output swipe_class_t            result
);

    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic        too_short;
    logic [39:0] scaled_x;
    logic [39:0] scaled_y;
    logic [39:0] ratio_x;
    logic [39:0] ratio_y;

    assign mag_x = sum_x[31] ? (~sum_x + 32'd1) : sum_x;
    assign mag_y = sum_y[31] ? (~sum_y + 32'd1) : sum_y;

    assign too_short = (mag_x < {16'd0, min_travel}) && (mag_y < {16'd0, min_travel});

    assign scaled_x = {4'd0, mag_x, 4'd0};
    assign scaled_y = {4'd0, mag_y, 4'd0};
    assign ratio_x  = {8'd0, mag_x} * {32'd0, axis_ratio};
    assign ratio_y  = {8'd0, mag_y} * {32'd0, axis_ratio};

    always_comb
    begin
        result.hit  = 1'b0;
        result.code = TRIG_LEFT;
        if (!too_short)
        begin
            if (scaled_x >= ratio_y)
            begin
                result.hit  = 1'b1;
                result.code = sum_x[31] ? TRIG_LEFT : TRIG_RIGHT;
            end
            else if (scaled_y >= ratio_x)
            begin
                result.hit  = 1'b1;
                result.code = sum_y[31] ? TRIG_UP : TRIG_DOWN;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/touchpad_gesture_classifier_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touchpad gesture classifier
// Claims or forwards each touchpad gesture event and fires swipe and pinch
// triggers at the end of claimed gestures.
// ----------------------------------------------------------------------------
// Each event passes an input register, then a result register.
// Throughput is one event per cycle while out_stall does not hold a valid
// result; classification and gesture state update are combinational between.
// Reset clears the valid flags, claim flags and swipe sums, sets the last
// pinch scale to one and loads the configuration registers with defaults.
// ----------------------------------------------------------------------------
module touchpad_gesture_classifier_unit
    import tgc_pkg::*;
#(
    parameter int SWIPE_FINGERS = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [3:0]  finger_count,
    input  wire logic signed [15:0] delta_x,
    input  wire logic signed [15:0] delta_y,
    input  wire logic [15:0] pinch_scale_in,
    input  wire logic        was_cancelled,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             forward,
    output logic             fired,
    output logic [2:0]       trigger_code
);

    logic [5:0]  trigger_enable_reg;
    logic        forward_enable_reg;
    logic [15:0] swipe_min_travel_reg;
    logic [7:0]  axis_ratio_reg;
    logic [15:0] pinch_in_limit_reg;
    logic [15:0] pinch_out_limit_reg;

    logic        in_valid_reg;
    mode_t       mode_reg;
    logic [3:0]  finger_count_reg;
    logic signed [15:0] delta_x_reg;
    logic signed [15:0] delta_y_reg;
    logic [15:0] scale_in_reg;
    logic        cancelled_reg;

    logic signed [31:0] sum_x_reg;
    logic signed [31:0] sum_y_reg;
    logic signed [31:0] sum_x_next;
    logic signed [31:0] sum_y_next;
    logic        swipe_owned_reg;
    logic        swipe_owned_next;
    logic [15:0] last_scale_reg;
    logic [15:0] last_scale_next;
    logic        pinch_owned_reg;
    logic        pinch_owned_next;

    logic        out_valid_reg;
    logic        forward_reg;
    logic        fired_reg;
    trig_code_t  code_reg;

    logic        forward_next;
    logic        cls_hit;
    trig_code_t  cls_code;
    logic        fire;

    logic        advance;
    logic        in_accept;

    swipe_class_t swipe_result;

    logic signed [32:0] add_x;
    logic signed [32:0] add_y;
    logic signed [31:0] sat_x;
    logic signed [31:0] sat_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_enable_reg   <= 6'd0;
            forward_enable_reg   <= 1'b0;
            swipe_min_travel_reg <= 16'd960;
            axis_ratio_reg       <= 8'd24;
            pinch_in_limit_reg   <= 16'd205;
            pinch_out_limit_reg  <= 16'd320;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_ENABLE:   trigger_enable_reg   <= cfg_data[5:0];
                CFG_FORWARD_ENABLE:   forward_enable_reg   <= cfg_data[0];
                CFG_SWIPE_MIN_TRAVEL: swipe_min_travel_reg <= cfg_data;
                CFG_AXIS_RATIO:       axis_ratio_reg       <= cfg_data[7:0];
                CFG_PINCH_IN_LIMIT:   pinch_in_limit_reg   <= cfg_data;
                CFG_PINCH_OUT_LIMIT:  pinch_out_limit_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The result stage moves whenever it is empty or its transaction completes.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg         <= mode_t'(mode);
            finger_count_reg <= finger_count;
            delta_x_reg      <= delta_x;
            delta_y_reg      <= delta_y;
            scale_in_reg     <= pinch_scale_in;
            cancelled_reg    <= was_cancelled;
        end
    end

    tgc_swipe_eval u_swipe_eval (
        .sum_x      (sum_x_reg),
        .sum_y      (sum_y_reg),
        .min_travel (swipe_min_travel_reg),
        .axis_ratio (axis_ratio_reg),
        .result     (swipe_result)
    );

    assign add_x = {sum_x_reg[31], sum_x_reg} + 33'(delta_x_reg);
    assign add_y = {sum_y_reg[31], sum_y_reg} + 33'(delta_y_reg);

    always_comb
    begin
        sat_x = add_x[31:0];
        if (add_x[32] != add_x[31])
        begin
            sat_x = add_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        sat_y = add_y[31:0];
        if (add_y[32] != add_y[31])
        begin
            sat_y = add_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_comb
    begin
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        swipe_owned_next = swipe_owned_reg;
        last_scale_next  = last_scale_reg;
        pinch_owned_next = pinch_owned_reg;
        forward_next     = 1'b0;
        cls_hit          = 1'b0;
        cls_code         = TRIG_LEFT;

        unique case (mode_reg)
            MODE_SWIPE_BEGIN:
            begin
                sum_x_next       = 32'sd0;
                sum_y_next       = 32'sd0;
                swipe_owned_next = (finger_count_reg == 4'(SWIPE_FINGERS))
                                   && ((trigger_enable_reg & SWIPE_TRIGGER_MASK) != 6'd0);
                forward_next     = !swipe_owned_next && forward_enable_reg;
            end
            MODE_SWIPE_UPDATE:
            begin
                if (swipe_owned_reg)
                begin
                    sum_x_next = sat_x;
                    sum_y_next = sat_y;
                end
                else
                begin
                    forward_next = forward_enable_reg;
                end
            end
            MODE_SWIPE_END:
            begin
                if (!swipe_owned_reg)
                begin
                    forward_next = forward_enable_reg;
                end
                else
                begin
                    swipe_owned_next = 1'b0;
                    cls_hit          = !cancelled_reg && swipe_result.hit;
                    cls_code         = swipe_result.code;
                end
            end
            MODE_PINCH_BEGIN:
            begin
                last_scale_next  = SCALE_ONE;
                pinch_owned_next = (trigger_enable_reg & PINCH_TRIGGER_MASK) != 6'd0;
                forward_next     = !pinch_owned_next && forward_enable_reg;
            end
            MODE_PINCH_UPDATE:
            begin
                if (pinch_owned_reg)
                begin
                    last_scale_next = scale_in_reg;
                end
                else
                begin
                    forward_next = forward_enable_reg;
                end
            end
            MODE_PINCH_END:
            begin
                if (!pinch_owned_reg)
                begin
                    forward_next = forward_enable_reg;
                end
                else
                begin
                    pinch_owned_next = 1'b0;
                    if (!cancelled_reg)
                    begin
                        if (last_scale_reg <= pinch_in_limit_reg)
                        begin
                            cls_hit  = 1'b1;
                            cls_code = TRIG_PINCH_IN;
                        end
                        else if (last_scale_reg >= pinch_out_limit_reg)
                        begin
                            cls_hit  = 1'b1;
                            cls_code = TRIG_PINCH_OUT;
                        end
                    end
                end
            end
            MODE_HOLD_BEGIN, MODE_HOLD_END:
            begin
                forward_next = forward_enable_reg;
            end
            default:
            begin
                forward_next = forward_enable_reg;
            end
        endcase
    end

    assign fire = cls_hit && trigger_enable_reg[cls_code];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg       <= 32'sd0;
            sum_y_reg       <= 32'sd0;
            swipe_owned_reg <= 1'b0;
            last_scale_reg  <= SCALE_ONE;
            pinch_owned_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                sum_x_reg       <= sum_x_next;
                sum_y_reg       <= sum_y_next;
                swipe_owned_reg <= swipe_owned_next;
                last_scale_reg  <= last_scale_next;
                pinch_owned_reg <= pinch_owned_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            forward_reg <= forward_next;
            fired_reg   <= fire;
            code_reg    <= fire ? cls_code : TRIG_LEFT;
        end
    end

    assign out_valid    = out_valid_reg;
    assign forward      = forward_reg;
    assign fired        = fired_reg;
    assign trigger_code = code_reg;

`ifndef SYNTHESIS
    a_fired_not_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(forward_reg && fired_reg))
        else $error("A fired event is also marked for forwarding.");

    a_code_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !fired_reg) |-> (code_reg == TRIG_LEFT))
        else $error("Trigger code is not zero on an event that did not fire.");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("Input stalled while the result stage could move.");

    a_swipe_end_drops_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && mode_reg == MODE_SWIPE_END) |=> !swipe_owned_reg)
        else $error("Swipe claim survived a swipe end event.");

    a_pinch_begin_resets_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && mode_reg == MODE_PINCH_BEGIN)
        |=> (last_scale_reg == SCALE_ONE))
        else $error("Pinch begin did not restore the scale to one.");
`endif

endmodule

`default_nettype wire
